### rtl/coe_pkg.sv
// ----------------------------------------------------------------------------
// coe_pkg
// Shared widths, register map and reset values of the clock offset estimator.
// ----------------------------------------------------------------------------
package coe_pkg;

  // timestamp and result widths
  localparam int TIME_W = 48;
  localparam int OFF_W  = 49;
  localparam int DLY_W  = 50;
  localparam int MIN_W  = 4;
  localparam int HELD_W = 4;

  // default window depth
  localparam int WINDOW_DEF = 8;

  // configuration port
  localparam int APB_DW = 64;
  localparam int APB_AW = 4;

  // register reset values
  localparam logic [TIME_W-1:0] THRESH_RESET = TIME_W'(1000000);
  localparam logic [MIN_W-1:0]  MIN_RESET    = MIN_W'(4);

  // register index, taken from the 8-byte word address
  typedef enum logic [0:0] {
    REG_STEP_THRESHOLD = 1'b0,
    REG_MIN_SAMPLES    = 1'b1
  } reg_idx_t;

endpackage

### rtl/coe_probe_if.sv
// ----------------------------------------------------------------------------
// coe_probe_if
// Probe channel: four 48-bit timestamps with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface coe_probe_if import coe_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] master_send_time;
  logic [TIME_W-1:0] remote_receive_time;
  logic [TIME_W-1:0] remote_reply_time;
  logic [TIME_W-1:0] local_receive_time;

  modport source (
    output valid, master_send_time, remote_receive_time,
           remote_reply_time, local_receive_time,
    input  ready
  );

  modport sink (
    input  valid, master_send_time, remote_receive_time,
           remote_reply_time, local_receive_time,
    output ready
  );

endinterface

### rtl/coe_result_if.sv
// ----------------------------------------------------------------------------
// coe_result_if
// Result channel: offset estimate and window status with valid/ready.
// ----------------------------------------------------------------------------
interface coe_result_if import coe_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic                    estimate_valid;
  logic signed [OFF_W-1:0] offset_estimate;
  logic                    window_discarded;
  logic [HELD_W-1:0]       samples_held;

  modport source (
    output valid, estimate_valid, offset_estimate, window_discarded, samples_held,
    input  ready
  );

  modport sink (
    input  valid, estimate_valid, offset_estimate, window_discarded, samples_held,
    output ready
  );

endinterface

### rtl/coe_ram.sv
// ----------------------------------------------------------------------------
// coe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module coe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/clock_offset_min_delay_estimator.sv
// ----------------------------------------------------------------------------
// clock_offset_min_delay_estimator
// Computes offset and round-trip delay of each four-timestamp probe, keeps a
// ring of recent samples, drops the ring on an offset step, and reports the
// offset of the minimum-delay sample.
//
//   channel  dir  handshake            payload
//   probe    in   valid/ready          t1..t4, 48 bit each
//   result   out  valid/ready          estimate_valid, offset_estimate,
//                                      window_discarded, samples_held
//   apb      in   psel/penable/pready  step_threshold, min_samples
//
// After acceptance a probe goes through the offset/delay arithmetic, the step
// test and the ring update with its RAM write, then a scan that reads the
// sample RAM one entry per cycle over the samples held and closes, and last
// the load of the output register. A new probe is taken only once the previous
// one has loaded the output register. Reset is synchronous; it clears the
// sequencer, ring pointers, configuration registers and output valid, but
// not the sample RAM, which is only read where written.
// A finished result sits in the output register; the next probe is accepted
// meanwhile and waits at the end of its work while the result is stalled.
// ----------------------------------------------------------------------------
module clock_offset_min_delay_estimator import coe_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  coe_probe_if.sink         probe,
  coe_result_if.source      result
);

  localparam int SW    = $clog2(WINDOW);
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int CMPW  = (CW > MIN_W) ? CW : MIN_W;
  localparam int RAM_W = OFF_W + DLY_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW - 1);
  localparam logic [CW-1:0] FULL      = CW'(WINDOW);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SUM  = 6'b000010,
    S_STEP = 6'b000100,
    S_UPD  = 6'b001000,
    S_SCAN = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [TIME_W-1:0] step_threshold;
  logic [MIN_W-1:0]  min_samples;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  // datapath registers
  logic signed [OFF_W-1:0] a_diff;
  logic signed [OFF_W-1:0] b_diff;
  logic signed [OFF_W-1:0] offset;
  logic signed [DLY_W-1:0] delay;
  logic signed [DLY_W-1:0] step;
  logic signed [OFF_W-1:0] last_offset;
  logic [SW-1:0]           write_slot;
  logic [CW-1:0]           sample_count;
  logic                    discarded;

  // scan registers
  logic [SW-1:0]           scan_ptr;
  logic [CW-1:0]           scan_left;
  logic                    rd_pend;
  logic                    first;
  logic signed [DLY_W-1:0] best_delay;
  logic signed [OFF_W-1:0] best_offset;

  // output registers
  logic                    out_valid;
  logic                    out_est_valid;
  logic signed [OFF_W-1:0] out_offset;
  logic                    out_discarded;
  logic [HELD_W-1:0]       out_held;

  // combinational helpers
  logic signed [DLY_W-1:0] sum_ab;
  logic signed [DLY_W-1:0] sum_rnd;
  logic signed [DLY_W-1:0] th_s;
  logic                    exceed;
  logic                    do_discard;
  logic [SW-1:0]           slot_base;
  logic [CW-1:0]           count_base;
  logic [SW-1:0]           slot_new;
  logic [CW-1:0]           count_new;
  logic                    est_valid;
  logic                    accept;
  logic                    out_free;

  // sample ram
  logic                    ram_we;
  logic                    ram_re;
  logic [RAM_W-1:0]        ram_wdata;
  logic [RAM_W-1:0]        ram_rdata;
  logic signed [DLY_W-1:0] rd_delay;
  logic signed [OFF_W-1:0] rd_offset;
  logic                    take;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_STEP_THRESHOLD: prdata = APB_DW'(step_threshold);
      REG_MIN_SAMPLES:    prdata = APB_DW'(min_samples);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_threshold <= THRESH_RESET;
      min_samples    <= MIN_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_STEP_THRESHOLD: step_threshold <= pwdata[TIME_W-1:0];
        REG_MIN_SAMPLES:    min_samples    <= pwdata[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign probe.ready = (state == S_IDLE);
  assign accept      = probe.valid && probe.ready;
  assign out_free    = !out_valid || result.ready;

  // offset and delay from the two partial differences
  assign sum_ab  = {a_diff[OFF_W-1], a_diff} + {b_diff[OFF_W-1], b_diff};
  assign sum_rnd = sum_ab + DLY_W'(sum_ab[DLY_W-1]);

  // step test and ring update
  assign th_s       = signed'({2'b00, step_threshold});
  assign exceed     = (step > th_s) || (step < -th_s);
  assign do_discard = (sample_count != '0) && exceed;
  assign slot_base  = do_discard ? '0 : write_slot;
  assign count_base = do_discard ? '0 : sample_count;
  assign slot_new   = (slot_base == LAST_SLOT) ? '0 : slot_base + 1'b1;
  assign count_new  = (count_base == FULL) ? count_base : count_base + 1'b1;
  assign est_valid  = CMPW'(sample_count) >= CMPW'(min_samples);

  // ram ports
  assign ram_we    = (state == S_UPD);
  assign ram_wdata = {offset, delay};
  assign ram_re    = (state == S_SCAN) && (scan_left != '0);
  assign rd_delay  = signed'(ram_rdata[DLY_W-1:0]);
  assign rd_offset = signed'(ram_rdata[RAM_W-1:DLY_W]);
  assign take      = first || (rd_delay <= best_delay);

  coe_ram #(
    .WIDTH (RAM_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_base),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_ptr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_SUM;
      S_SUM:  state_next = S_STEP;
      S_STEP: state_next = S_UPD;
      S_UPD:  state_next = S_SCAN;
      S_SCAN: if ((scan_left == '0) && !rd_pend) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_diff <= signed'({1'b0, probe.remote_receive_time} - {1'b0, probe.master_send_time});
      b_diff <= signed'({1'b0, probe.remote_reply_time} - {1'b0, probe.local_receive_time});
    end
    if (state == S_SUM) begin
      offset <= sum_rnd[DLY_W-1:1];
      delay  <= {a_diff[OFF_W-1], a_diff} - {b_diff[OFF_W-1], b_diff};
    end
    if (state == S_STEP) begin
      step <= {offset[OFF_W-1], offset} - {last_offset[OFF_W-1], last_offset};
    end
    if (state == S_UPD) begin
      last_offset <= offset;
    end
  end

  // ring pointers and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      sample_count <= '0;
      discarded    <= 1'b0;
      scan_ptr     <= '0;
      scan_left    <= '0;
      rd_pend      <= 1'b0;
      first        <= 1'b0;
    end else begin
      if (state == S_UPD) begin
        write_slot   <= slot_new;
        sample_count <= count_new;
        discarded    <= do_discard;
        scan_ptr     <= (count_new == FULL) ? slot_new : '0;
        scan_left    <= count_new;
        rd_pend      <= 1'b0;
        first        <= 1'b1;
      end else if (state == S_SCAN) begin
        rd_pend <= ram_re;
        if (ram_re) begin
          scan_ptr  <= (scan_ptr == LAST_SLOT) ? '0 : scan_ptr + 1'b1;
          scan_left <= scan_left - 1'b1;
        end
        if (rd_pend) begin
          first <= 1'b0;
        end
      end
    end
  end

  // running minimum over the scanned entries, newer wins a tie
  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && rd_pend && take) begin
      best_delay  <= rd_delay;
      best_offset <= rd_offset;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_est_valid <= est_valid;
      out_offset    <= est_valid ? best_offset : '0;
      out_discarded <= discarded;
      out_held      <= HELD_W'(sample_count);
    end
  end

  assign result.valid            = out_valid;
  assign result.estimate_valid   = out_est_valid;
  assign result.offset_estimate  = out_offset;
  assign result.window_discarded = out_discarded;
  assign result.samples_held     = out_held;

endmodule

### rtl/coe_checker.sv
// ----------------------------------------------------------------------------
// coe_checker
// Port-level checks of the clock offset estimator, bound to the top level.
// ----------------------------------------------------------------------------
module coe_checker import coe_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    probe_valid,
  input logic                    probe_ready,
  input logic                    result_valid,
  input logic                    result_ready,
  input logic                    estimate_valid,
  input logic signed [OFF_W-1:0] offset_estimate,
  input logic                    window_discarded,
  input logic [HELD_W-1:0]       samples_held
);

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(offset_estimate))
    else $error("result beat changed while stalled");

  // the block is busy in the cycle after taking a probe
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    probe_valid && probe_ready |=> !probe_ready)
    else $error("probe accepted on back-to-back cycles");

  // no estimate means a zero offset field
  a_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !estimate_valid |-> offset_estimate == '0)
    else $error("offset reported without a valid estimate");

  // a discard leaves only the new sample
  a_discard_one_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && window_discarded |-> samples_held == HELD_W'(1))
    else $error("discard left more than one sample");

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind clock_offset_min_delay_estimator coe_checker u_coe_checker (
  .clk              (clk),
  .rst              (rst),
  .probe_valid      (probe.valid),
  .probe_ready      (probe.ready),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .estimate_valid   (result.estimate_valid),
  .offset_estimate  (result.offset_estimate),
  .window_discarded (result.window_discarded),
  .samples_held     (result.samples_held)
);
